/* hdl/gbk_pkg.sv */
// Shared types and constants for the group-by-key block.
// Holds field widths, operation and status codes, FSM states and the
// token and write-command structs used between the top level and its cells.
`default_nettype none

package gbk_pkg;

  // Default table geometry
  localparam int MAX_GROUPS_DEF    = 16;
  localparam int MAX_PER_GROUP_DEF = 64;

  // Transfer field widths
  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int ITEM_W  = 16;
  localparam int GSEL_W  = 4;
  localparam int PSEL_W  = 6;
  localparam int ST_W    = 2;
  localparam int GIDX_W  = 10;
  localparam int GTOT_W  = 5;
  localparam int ITOT_W  = 11;
  localparam int GSIZE_W = 7;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_GROUP = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  // Request token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [GSEL_W-1:0] gsel;
    logic [PSEL_W-1:0] psel;
    logic              found;   // key matched, or selected group is in use
    logic              full;    // matched group has no room left
    logic              pos_ok;  // selected position is below the group count
    logic [GSEL_W-1:0] grp;     // matched group, low bits
    logic [GIDX_W-1:0] cnt_lo;  // count of matched/selected group, low bits
    logic [GIDX_W-1:0] prefix;  // counts of earlier groups, low bits
    logic [KEY_W-1:0]  gkey;    // key of selected group
  } tok_t;

  // Table update broadcast to every cell
  typedef struct packed {
    logic             clear;
    logic             inc;   // bump the count of the matched cell
    logic             open;  // claim the first free cell
    logic [KEY_W-1:0] key;
  } wr_t;

endpackage

`default_nettype wire

/* hdl/gbk_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module gbk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/gbk_cell.sv */
// One group slot of the chain: key, item count and in-use flag.
// Updates the passing request token and hands it to the next cell.
// Depends on gbk_pkg.
`default_nettype none

module gbk_cell #(
  parameter int MAX_PER_GROUP = gbk_pkg::MAX_PER_GROUP_DEF,
  parameter int CELL_IDX      = 0,
  parameter int CW            = $clog2(MAX_PER_GROUP + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire gbk_pkg::tok_t tok_in,
  output      gbk_pkg::tok_t tok_out,
  input  wire gbk_pkg::wr_t  wr,
  input  wire logic          prev_used,
  output      logic          used,
  output      logic          match
);

  logic [gbk_pkg::KEY_W-1:0]  ckey;
  logic [CW-1:0]              count;
  logic [gbk_pkg::GIDX_W-1:0] cnt_ext;
  logic                       op_ins;
  logic                       op_rd;
  logic                       key_hit;
  logic                       sel_here;
  logic                       below_sel;
  gbk_pkg::tok_t              tok_next;

  assign cnt_ext   = gbk_pkg::GIDX_W'(count);
  assign op_ins    = tok_in.valid && (tok_in.op == gbk_pkg::OP_INSERT);
  assign op_rd     = tok_in.valid && (tok_in.op == gbk_pkg::OP_READ);
  assign key_hit   = op_ins && used && !tok_in.found && (tok_in.key == ckey);
  assign sel_here  = op_rd && (int'(tok_in.gsel) == CELL_IDX);
  assign below_sel = op_rd && (CELL_IDX < int'(tok_in.gsel));

  // Match the key, select the read group, and accumulate earlier counts
  always_comb begin
    tok_next = tok_in;
    if (key_hit) begin
      tok_next.found  = 1'b1;
      tok_next.grp    = gbk_pkg::GSEL_W'(CELL_IDX);
      tok_next.cnt_lo = cnt_ext;
      tok_next.full   = (int'(count) >= MAX_PER_GROUP);
    end else if ((op_ins && !tok_in.found) || below_sel) begin
      tok_next.prefix = tok_in.prefix + cnt_ext;
    end
    if (sel_here) begin
      tok_next.found  = used;
      tok_next.cnt_lo = cnt_ext;
      tok_next.gkey   = ckey;
      tok_next.pos_ok = (int'(tok_in.psel) < int'(count));
    end
  end

  // Pass the token on
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // Remember whether the last request through here was an insert that matched here
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (tok_in.valid) begin
      match <= key_hit;
    end
  end

  // Apply table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      count <= '0;
    end else if (wr.clear) begin
      used  <= 1'b0;
      count <= '0;
    end else if (wr.inc && match) begin
      count <= count + CW'(1);
    end else if (wr.open && !used && prev_used) begin
      used  <= 1'b1;
      count <= CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.open && !used && prev_used && !wr.clear) begin
      ckey <= wr.key;
    end
  end

endmodule

`default_nettype wire

/* hdl/group_by_key_with_offsets.sv */
// Top level of the group-by-key table with prefix offsets.
// Depends on gbk_pkg, gbk_cell and gbk_ram.
//
// Usage:
//   One request enters on the s_axis channel (opcode in tuser) and gives one
//   result on the m_axis channel (status in tuser). Clear empties the table,
//   insert adds an item to the group of its key (opening a new group on a
//   miss), read returns a stored item with its key and global index.
//   The request walks a chain of MAX_GROUPS cells, one per cycle; each cell
//   holds one group's key and count, compares the key and adds its count to
//   the running prefix. The token leaving the chain is held, the result is
//   then registered in the output register, and only after that commit is a
//   new request taken, so the block works on one request at a time. Item
//   identifiers sit in a RAM of MAX_GROUPS * MAX_PER_GROUP entries.
//   Reset empties the table; no clearing pass is needed. While the receiver
//   stalls, the finished result is held in the output register; the next
//   request is still accepted and walks the chain, and only its commit waits
//   until the output register is free.
`default_nettype none

module group_by_key_with_offsets #(
  parameter int MAX_GROUPS    = gbk_pkg::MAX_GROUPS_DEF,
  parameter int MAX_PER_GROUP = gbk_pkg::MAX_PER_GROUP_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // key [31:0], item_id [47:32], group_index [51:48], position [57:52]
  input  wire logic [gbk_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  wire logic [gbk_pkg::OP_W-1:0]       s_axis_tuser,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_group [3:0], out_position [9:4], out_item [25:10], out_key [57:26],
  // global_index [67:58], group_total [72:68], item_total [83:73],
  // group_size [90:84]
  output      logic [gbk_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output      logic [gbk_pkg::ST_W-1:0]       m_axis_tuser
);

  localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GCW   = $clog2(MAX_GROUPS + 1);
  localparam int SLOTS = MAX_GROUPS * MAX_PER_GROUP;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TCW   = $clog2(SLOTS + 1);
  localparam int CW    = $clog2(MAX_PER_GROUP + 1);

  gbk_pkg::state_t                state;
  gbk_pkg::state_t                state_next;
  gbk_pkg::tok_t                  tok [MAX_GROUPS+1];
  gbk_pkg::tok_t                  res_tok;
  gbk_pkg::wr_t                   wr;
  logic [MAX_GROUPS-1:0]          used;
  logic [MAX_GROUPS-1:0]          match;
  logic [GCW-1:0]                 groups_used;
  logic [GCW-1:0]                 groups_used_next;
  logic [TCW-1:0]                 items_used;
  logic [TCW-1:0]                 items_used_next;
  logic [gbk_pkg::ITEM_W-1:0]     req_item;
  logic [GW-1:0]                  hit_g;
  logic                           in_xfer;
  logic                           commit;
  logic                           ram_en;
  logic                           ram_we;
  logic [AW-1:0]                  ram_addr;
  logic [gbk_pkg::ITEM_W-1:0]     ram_rdata;
  logic [gbk_pkg::ST_W-1:0]       r_status;
  logic [gbk_pkg::GSEL_W-1:0]     r_group;
  logic [gbk_pkg::PSEL_W-1:0]     r_pos;
  logic [gbk_pkg::ITEM_W-1:0]     r_item;
  logic [gbk_pkg::KEY_W-1:0]      r_key;
  logic [gbk_pkg::GIDX_W-1:0]     r_gidx;
  logic [gbk_pkg::GSIZE_W-1:0]    r_size;
  logic [gbk_pkg::GIDX_W-1:0]     size_inc;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Build the fresh token from the input transfer
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = in_xfer;
    tok[0].op     = s_axis_tuser;
    tok[0].key    = s_axis_tdata[31:0];
    tok[0].gsel   = s_axis_tdata[51:48];
    tok[0].psel   = s_axis_tdata[57:52];
  end

  // Chain of group cells
  for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
    logic prev_used;
    if (i == 0) begin : g_first
      assign prev_used = 1'b1;
    end else begin : g_rest
      assign prev_used = used[i-1];
    end
    gbk_cell #(
      .MAX_PER_GROUP (MAX_PER_GROUP),
      .CELL_IDX      (i),
      .CW            (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1]),
      .wr        (wr),
      .prev_used (prev_used),
      .used      (used[i]),
      .match     (match[i])
    );
  end

  // Encode the matched cell
  always_comb begin
    hit_g = '0;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      if (match[i]) begin
        hit_g = hit_g | GW'(i);
      end
    end
  end

  assign commit   = (state == gbk_pkg::S_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign size_inc = res_tok.cnt_lo + gbk_pkg::GIDX_W'(1);

  // Next state, table updates and result
  always_comb begin
    state_next       = state;
    s_axis_tready    = (state == gbk_pkg::S_IDLE);
    wr               = '0;
    wr.key           = res_tok.key;
    groups_used_next = groups_used;
    items_used_next  = items_used;
    ram_en           = 1'b0;
    ram_we           = 1'b0;
    ram_addr         = '0;
    r_status         = gbk_pkg::ST_OK;
    r_group          = '0;
    r_pos            = '0;
    r_item           = '0;
    r_key            = '0;
    r_gidx           = '0;
    r_size           = '0;

    case (state)
      gbk_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_next = gbk_pkg::S_RUN;
          ram_en     = (s_axis_tuser == gbk_pkg::OP_READ);
        end
      end
      gbk_pkg::S_RUN: begin
        if (tok[MAX_GROUPS].valid) begin
          state_next = gbk_pkg::S_DONE;
        end
      end
      gbk_pkg::S_DONE: begin
        if (commit) begin
          state_next = gbk_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gbk_pkg::S_IDLE;
      end
    endcase

    case (res_tok.op)
      gbk_pkg::OP_CLEAR: begin
        wr.clear         = commit;
        groups_used_next = '0;
        items_used_next  = '0;
      end
      gbk_pkg::OP_INSERT: begin
        r_key = res_tok.key;
        if (res_tok.found && res_tok.full) begin
          r_status = gbk_pkg::ST_FULL;
          r_group  = res_tok.grp;
          r_size   = res_tok.cnt_lo[gbk_pkg::GSIZE_W-1:0];
        end else if (res_tok.found) begin
          wr.inc          = commit;
          ram_we          = 1'b1;
          ram_addr        = AW'(int'(hit_g) * MAX_PER_GROUP + int'(res_tok.cnt_lo));
          items_used_next = items_used + TCW'(1);
          r_group         = res_tok.grp;
          r_pos           = res_tok.cnt_lo[gbk_pkg::PSEL_W-1:0];
          r_gidx          = res_tok.prefix + res_tok.cnt_lo;
          r_size          = size_inc[gbk_pkg::GSIZE_W-1:0];
        end else if (int'(groups_used) >= MAX_GROUPS) begin
          r_status = gbk_pkg::ST_NO_GROUP;
        end else begin
          wr.open          = commit;
          ram_we           = 1'b1;
          ram_addr         = AW'(int'(groups_used) * MAX_PER_GROUP);
          items_used_next  = items_used + TCW'(1);
          groups_used_next = groups_used + GCW'(1);
          r_group          = gbk_pkg::GSEL_W'(groups_used);
          r_gidx           = res_tok.prefix;
          r_size           = gbk_pkg::GSIZE_W'(1);
        end
      end
      gbk_pkg::OP_READ: begin
        r_group = res_tok.gsel;
        r_pos   = res_tok.psel;
        if (!res_tok.found) begin
          r_status = gbk_pkg::ST_RANGE;
        end else if (!res_tok.pos_ok) begin
          r_status = gbk_pkg::ST_RANGE;
          r_size   = res_tok.cnt_lo[gbk_pkg::GSIZE_W-1:0];
        end else begin
          r_item = ram_rdata;
          r_key  = res_tok.gkey;
          r_gidx = res_tok.prefix + gbk_pkg::GIDX_W'(res_tok.psel);
          r_size = res_tok.cnt_lo[gbk_pkg::GSIZE_W-1:0];
        end
      end
      default: begin
        r_status = gbk_pkg::ST_RANGE;
      end
    endcase

    // Only the commit cycle writes the slot RAM; otherwise address the read request
    if (state == gbk_pkg::S_DONE) begin
      ram_en = commit && ram_we;
    end else begin
      ram_we   = 1'b0;
      ram_addr = AW'(int'(s_axis_tdata[51:48]) * MAX_PER_GROUP
                     + int'(s_axis_tdata[57:52]));
    end
  end

  // State register and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gbk_pkg::S_IDLE;
      groups_used <= '0;
      items_used  <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        groups_used <= groups_used_next;
        items_used  <= items_used_next;
      end
    end
  end

  // Hold the request item and the token leaving the chain
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_item <= s_axis_tdata[47:32];
    end
    if (state == gbk_pkg::S_RUN && tok[MAX_GROUPS].valid) begin
      res_tok <= tok[MAX_GROUPS];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tuser <= r_status;
      m_axis_tdata <= {5'd0,
                       r_size,
                       gbk_pkg::ITOT_W'(items_used_next),
                       gbk_pkg::GTOT_W'(groups_used_next),
                       r_gidx,
                       r_key,
                       r_item,
                       r_pos,
                       r_group};
    end
  end

  // Item identifier store
  gbk_ram #(
    .WIDTH (gbk_pkg::ITEM_W),
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_slots (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req_item),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for group_by_key_with_offsets: keeps its own copy of the
// group table and checks every result on the master side field by field.
// Depends on gbk_pkg and the block's RTL.

module tb;

  localparam int GROUPS       = gbk_pkg::MAX_GROUPS_DEF;
  localparam int PER_GROUP    = gbk_pkg::MAX_PER_GROUP_DEF;
  localparam int SLOTS        = GROUPS * PER_GROUP;
  localparam int KEY_POOL     = 20;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 330;

  // Opcode value the block does not define
  localparam logic [gbk_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    gbk_pkg::status_t            status;
    logic [gbk_pkg::GSEL_W-1:0]  grp;
    logic [gbk_pkg::PSEL_W-1:0]  pos;
    logic [gbk_pkg::ITEM_W-1:0]  item;
    logic [gbk_pkg::KEY_W-1:0]   key;
    logic [gbk_pkg::GIDX_W-1:0]  gidx;
    logic [gbk_pkg::GTOT_W-1:0]  gtot;
    logic [gbk_pkg::ITOT_W-1:0]  itot;
    logic [gbk_pkg::GSIZE_W-1:0] gsize;
  } reply_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [gbk_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [gbk_pkg::OP_W-1:0]       s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [gbk_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [gbk_pkg::ST_W-1:0]       m_axis_tuser;

  // Shadow copy of the group table
  logic [gbk_pkg::KEY_W-1:0]  grp_key [GROUPS];
  int                         grp_count [GROUPS];
  logic [gbk_pkg::ITEM_W-1:0] slot_item [SLOTS];
  int                         groups_open = 0;
  int                         items_held = 0;

  reply_t table_replies[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     steady = 1'b0;

  group_by_key_with_offsets dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < GROUPS; i++) begin
      grp_count[i] = 0;
    end
  end

  // Sum of the counts of all groups ahead of g
  function automatic int prefix_of(int g);
    int sum;
    sum = 0;
    for (int i = 0; i < g; i++) begin
      sum += grp_count[i];
    end
    return sum;
  endfunction

  // Apply one request to the shadow table and return the result it gives
  function automatic reply_t apply_to_table(logic [gbk_pkg::OP_W-1:0] op,
                                            logic [gbk_pkg::KEY_W-1:0] key,
                                            logic [gbk_pkg::ITEM_W-1:0] item,
                                            logic [gbk_pkg::GSEL_W-1:0] gsel,
                                            logic [gbk_pkg::PSEL_W-1:0] psel);
    reply_t r;
    bit     hit;
    int     g;
    r = '0;
    hit = 1'b0;
    g = 0;
    case (op)
      gbk_pkg::OP_CLEAR: begin
        for (int i = 0; i < GROUPS; i++) begin
          grp_count[i] = 0;
        end
        groups_open = 0;
        items_held = 0;
        r.status = gbk_pkg::ST_OK;
      end
      gbk_pkg::OP_INSERT: begin
        for (int i = 0; i < groups_open; i++) begin
          if (!hit && grp_key[i] == key) begin
            g = i;
            hit = 1'b1;
          end
        end
        if (!hit && groups_open >= GROUPS) begin
          r.status = gbk_pkg::ST_NO_GROUP;
          r.key = key;
        end else if (hit && grp_count[g] >= PER_GROUP) begin
          r.status = gbk_pkg::ST_FULL;
          r.grp = gbk_pkg::GSEL_W'(g);
          r.key = key;
          r.gsize = gbk_pkg::GSIZE_W'(grp_count[g]);
        end else begin
          if (!hit) begin
            g = groups_open;
            grp_key[g] = key;
            grp_count[g] = 0;
            groups_open++;
          end
          slot_item[g * PER_GROUP + grp_count[g]] = item;
          r.status = gbk_pkg::ST_OK;
          r.grp = gbk_pkg::GSEL_W'(g);
          r.pos = gbk_pkg::PSEL_W'(grp_count[g]);
          r.key = key;
          r.gidx = gbk_pkg::GIDX_W'(prefix_of(g) + grp_count[g]);
          grp_count[g]++;
          items_held++;
          r.gsize = gbk_pkg::GSIZE_W'(grp_count[g]);
        end
      end
      gbk_pkg::OP_READ: begin
        r.grp = gsel;
        r.pos = psel;
        if (gsel >= groups_open) begin
          r.status = gbk_pkg::ST_RANGE;
        end else if (psel >= grp_count[gsel]) begin
          r.status = gbk_pkg::ST_RANGE;
          r.gsize = gbk_pkg::GSIZE_W'(grp_count[gsel]);
        end else begin
          r.status = gbk_pkg::ST_OK;
          r.item = slot_item[gsel * PER_GROUP + psel];
          r.key = grp_key[gsel];
          r.gidx = gbk_pkg::GIDX_W'(prefix_of(gsel) + psel);
          r.gsize = gbk_pkg::GSIZE_W'(grp_count[gsel]);
        end
      end
      default: begin
        r.status = gbk_pkg::ST_RANGE;
      end
    endcase
    r.gtot = gbk_pkg::GTOT_W'(groups_open);
    r.itot = gbk_pkg::ITOT_W'(items_held);
    return r;
  endfunction

  // Present one request at the falling edge and hold it until the transfer
  task automatic send_req(logic [gbk_pkg::OP_W-1:0] op, logic [gbk_pkg::KEY_W-1:0] key,
                          logic [gbk_pkg::ITEM_W-1:0] item,
                          logic [gbk_pkg::GSEL_W-1:0] gsel,
                          logic [gbk_pkg::PSEL_W-1:0] psel);
    int     gap;
    reply_t expected;
    gap = steady ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata = {6'b0, psel, gsel, item, key};
    s_axis_tuser = op;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected = apply_to_table(op, key, item, gsel, psel);
    table_replies = {table_replies, expected};
  endtask

  task automatic report_mismatch(string what, logic [gbk_pkg::KEY_W-1:0] got,
                                 logic [gbk_pkg::KEY_W-1:0] want);
    $display("tb: %0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [gbk_pkg::KEY_W-1:0] got,
                             logic [gbk_pkg::KEY_W-1:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_reply
    reply_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = gbk_pkg::status_t'(m_axis_tuser);
      got.grp    = m_axis_tdata[3:0];
      got.pos    = m_axis_tdata[9:4];
      got.item   = m_axis_tdata[25:10];
      got.key    = m_axis_tdata[57:26];
      got.gidx   = m_axis_tdata[67:58];
      got.gtot   = m_axis_tdata[72:68];
      got.itot   = m_axis_tdata[83:73];
      got.gsize  = m_axis_tdata[90:84];
      if (table_replies.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(got.status), '0);
      end else begin
        want = table_replies.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("out_group", 32'(got.grp), 32'(want.grp));
        check_field("out_position", 32'(got.pos), 32'(want.pos));
        check_field("out_item", 32'(got.item), 32'(want.item));
        check_field("out_key", got.key, want.key);
        check_field("global_index", 32'(got.gidx), 32'(want.gidx));
        check_field("group_total", 32'(got.gtot), 32'(want.gtot));
        check_field("item_total", 32'(got.itot), 32'(want.itot));
        check_field("group_size", 32'(got.gsize), 32'(want.gsize));
      end
    end
  end

  // Before each transfer, hold tready low for a random stall unless steady is set
  initial begin : result_sink
    int stall;
    @(negedge rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        m_axis_tready = 1'b0;
      end
      @(negedge clk);
      m_axis_tready = 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // End the run when neither side transfers for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Extremes of the fields, each opcode and the range error status on a small table
  task automatic test_directed();
    send_req(gbk_pkg::OP_CLEAR, '0, '0, '0, '0);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd0, 6'd0);
    send_req(gbk_pkg::OP_READ, '1, '1, 4'd15, 6'd63);
    send_req(gbk_pkg::OP_INSERT, 32'h0000_0000, 16'h0000, 4'd15, 6'd63);
    send_req(gbk_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, 6'd0);
    send_req(gbk_pkg::OP_INSERT, 32'h0000_0000, 16'h1234, '1, '1);
    send_req(gbk_pkg::OP_INSERT, 32'hA5A5_5A5A, 16'h8001, 4'd9, 6'd33);
    send_req(gbk_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h7FFE, 4'd6, 6'd30);
    send_req(gbk_pkg::OP_READ, '1, '1, 4'd0, 6'd0);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd0, 6'd1);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd1, 6'd1);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd2, 6'd0);
    // past the end of a group in use, then a group not in use
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd0, 6'd2);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd3, 6'd0);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd1, 6'd63);
    send_req(OP_UNUSED, '1, '1, '1, '1);
    send_req(OP_UNUSED, '0, '0, '0, '0);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd1, 6'd0);
    send_req(gbk_pkg::OP_CLEAR, '1, '1, '1, '1);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd0, 6'd0);
    send_req(gbk_pkg::OP_INSERT, 32'h8000_0001, 16'h0101, 4'd0, 6'd0);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd0, 6'd0);
  endtask

  // Open every group and fill one to the brim, then probe the table-full and
  // group-full cases
  task automatic test_fill_table();
    logic [gbk_pkg::KEY_W-1:0] keys [GROUPS];
    int                        deep;
    deep = $urandom_range(0, GROUPS - 1);
    for (int i = 0; i < GROUPS; i++) begin
      keys[i] = ($urandom & 32'hFFFF_FFF0) | 32'(i);
    end
    send_req(gbk_pkg::OP_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < GROUPS; i++) begin
      send_req(gbk_pkg::OP_INSERT, keys[i], 16'($urandom), 4'($urandom), 6'($urandom));
    end
    for (int n = 1; n < PER_GROUP; n++) begin
      steady = (n % 32) >= 24;
      send_req(gbk_pkg::OP_INSERT, keys[deep], 16'($urandom), 4'($urandom), 6'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        send_req(gbk_pkg::OP_READ, '0, '0, 4'($urandom_range(0, GROUPS - 1)),
                 6'($urandom_range(0, 63)));
      end
    end
    steady = 1'b0;
    send_req(gbk_pkg::OP_READ, '0, '0, 4'(deep), 6'd63);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd0, 6'd0);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd15, 6'd0);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'd7, 6'($urandom_range(0, 63)));
    send_req(gbk_pkg::OP_INSERT, keys[0] ^ 32'h0000_0100, 16'hBEEF, '0, '0);
    send_req(gbk_pkg::OP_INSERT, keys[deep], 16'hCAFE, '0, '0);
    send_req(gbk_pkg::OP_INSERT, keys[(deep + 1) % GROUPS], 16'hFFFF, '1, '1);
    send_req(gbk_pkg::OP_READ, '0, '0, 4'(deep), 6'd63);
    send_req(gbk_pkg::OP_CLEAR, '0, '0, '0, '0);
  endtask

  // Mostly inserts from a small key pool and reads of stored items, with noise
  task automatic test_random_mix(int count);
    logic [gbk_pkg::KEY_W-1:0]  keys [KEY_POOL];
    logic [gbk_pkg::GSEL_W-1:0] g;
    logic [gbk_pkg::PSEL_W-1:0] p;
    int                         pick, k;
    for (int i = 0; i < KEY_POOL; i++) begin
      keys[i] = $urandom;
    end
    for (int n = 0; n < count; n++) begin
      steady = (n % 120) >= 90;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_req(gbk_pkg::OP_CLEAR, $urandom, 16'($urandom), 4'($urandom), 6'($urandom));
        for (int i = 0; i < KEY_POOL; i++) begin
          keys[i] = $urandom;
        end
      end else if (pick < 58) begin
        // favor a few hot keys so groups grow deep
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, KEY_POOL - 1)
                                         : $urandom_range(0, 3);
        send_req(gbk_pkg::OP_INSERT, keys[k], 16'($urandom), 4'($urandom), 6'($urandom));
      end else if (pick < 96) begin
        if (groups_open > 0 && pick < 90) begin
          g = 4'($urandom_range(0, groups_open - 1));
          p = (grp_count[g] > 0) ? 6'($urandom_range(0, grp_count[g] - 1)) : 6'd0;
        end else begin
          g = 4'($urandom);
          p = 6'($urandom);
        end
        send_req(gbk_pkg::OP_READ, $urandom, 16'($urandom), g, p);
      end else begin
        send_req(OP_UNUSED, $urandom, 16'($urandom), 4'($urandom), 6'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_table();
    test_random_mix(RANDOM_ITEMS);
    // drop the request and let the last results come out
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait (table_replies.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
